[src/aar_pkg.sv]
// ----------------------------------------------------------------------------
// Accelerating auto-repeat package
// Shared types, codes and constants for the accelerating auto-repeat unit.
// ----------------------------------------------------------------------------
package aar_pkg;

    localparam int unsigned NUM_CFG_REGS = 8;
    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned CFG_DATA_W   = 16;
    localparam int unsigned TARGET_W     = 4;
    localparam int unsigned DIR_W        = 2;
    localparam int unsigned AMOUNT_W     = 5;
    localparam int unsigned COUNT_W      = 8;
    localparam int unsigned TIME_W       = 16;
    localparam int unsigned MULT_W       = 4;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_PRESS   = 2'd1,
        OP_RELEASE = 2'd2,
        OP_UNUSED  = 2'd3
    } opcode_t;

    localparam logic [CFG_IDX_W-1:0] REG_START_DELAY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_ST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_S1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_S2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_S1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_S2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MULT_S1      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MULT_S2      = 3'd7;

    localparam logic [DIR_W-1:0] DIR_ZERO = 2'b00;
    localparam logic [DIR_W-1:0] DIR_POS  = 2'b01;
    localparam logic [DIR_W-1:0] DIR_NEG  = 2'b11;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [TIME_W-1:0]  start_delay;
        logic [TIME_W-1:0]  interval_start;
        logic [TIME_W-1:0]  interval_stage1;
        logic [TIME_W-1:0]  interval_stage2;
        logic [COUNT_W-1:0] threshold1;
        logic [COUNT_W-1:0] threshold2;
        logic [MULT_W-1:0]  mult1;
        logic [MULT_W-1:0]  mult2;
    } aar_cfg_t;

    typedef struct packed {
        opcode_t             opcode;
        logic [TARGET_W-1:0] target;
        logic [DIR_W-1:0]    direction;
    } aar_cmd_t;

    typedef struct packed {
        logic                       valid;
        logic [TARGET_W-1:0]        target;
        logic signed [AMOUNT_W-1:0] amount;
    } aar_res_t;

endpackage

[src/aar_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Accelerating auto-repeat configuration registers
// Holds the delay, interval, threshold and multiplier settings.
// ----------------------------------------------------------------------------
module aar_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [aar_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [aar_pkg::CFG_DATA_W-1:0]     cfg_data,
    output aar_pkg::aar_cfg_t                  cfg
);
    import aar_pkg::*;

    aar_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_delay     <= 16'd400;
            cfg_reg.interval_start  <= 16'd150;
            cfg_reg.interval_stage1 <= 16'd80;
            cfg_reg.interval_stage2 <= 16'd40;
            cfg_reg.threshold1      <= 8'd5;
            cfg_reg.threshold2      <= 8'd15;
            cfg_reg.mult1           <= 4'd2;
            cfg_reg.mult2           <= 4'd5;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_START_DELAY:  cfg_reg.start_delay     <= cfg_data;
                REG_INTERVAL_ST:  cfg_reg.interval_start  <= cfg_data;
                REG_INTERVAL_S1:  cfg_reg.interval_stage1 <= cfg_data;
                REG_INTERVAL_S2:  cfg_reg.interval_stage2 <= cfg_data;
                REG_THRESHOLD_S1: cfg_reg.threshold1      <= cfg_data[COUNT_W-1:0];
                REG_THRESHOLD_S2: cfg_reg.threshold2      <= cfg_data[COUNT_W-1:0];
                REG_MULT_S1:      cfg_reg.mult1           <= cfg_data[MULT_W-1:0];
                REG_MULT_S2:      cfg_reg.mult2           <= cfg_data[MULT_W-1:0];
                default:          cfg_reg.start_delay     <= cfg_reg.start_delay;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/aar_core.sv]
// ----------------------------------------------------------------------------
// Accelerating auto-repeat core
// Hold state and the combinational update for one request.
// ----------------------------------------------------------------------------
module aar_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  aar_pkg::aar_cmd_t    cmd,
    input  aar_pkg::aar_cfg_t    cfg,
    output aar_pkg::aar_res_t    res
);
    import aar_pkg::*;

    logic                holding_reg,   holding_next;
    logic [TARGET_W-1:0] target_reg,    target_next;
    logic [DIR_W-1:0]    dir_reg,       dir_next;
    logic [COUNT_W-1:0]  count_reg,     count_next;
    logic [TIME_W-1:0]   countdown_reg, countdown_next;

    logic [TIME_W-1:0]          cd_dec;
    logic [COUNT_W-1:0]         count_inc;
    logic [MULT_W-1:0]          mult;
    logic [TIME_W-1:0]          interval;
    logic signed [AMOUNT_W-1:0] magnitude;
    logic signed [AMOUNT_W-1:0] repeat_amount;

    always_comb
    begin
        cd_dec    = (countdown_reg != '0) ? countdown_reg - 16'd1 : countdown_reg;
        count_inc = (count_reg != COUNT_MAX) ? count_reg + 8'd1 : count_reg;

        if (count_inc > cfg.threshold2)
            mult = cfg.mult2;
        else if (count_inc > cfg.threshold1)
            mult = cfg.mult1;
        else
            mult = 4'd1;

        if (count_inc < cfg.threshold1)
            interval = cfg.interval_start;
        else if (count_inc < cfg.threshold2)
            interval = cfg.interval_stage1;
        else
            interval = cfg.interval_stage2;

        magnitude     = signed'({1'b0, mult});
        repeat_amount = dir_reg[1] ? -magnitude : magnitude;
    end

    always_comb
    begin
        holding_next   = holding_reg;
        target_next    = target_reg;
        dir_next       = dir_reg;
        count_next     = count_reg;
        countdown_next = countdown_reg;
        res.valid      = 1'b0;
        res.target     = target_reg;
        res.amount     = repeat_amount;

        if (fire)
        begin
            unique case (cmd.opcode)
                OP_PRESS:
                begin
                    if (cmd.direction == DIR_ZERO)
                    begin
                        holding_next = 1'b0;
                        target_next  = '0;
                        dir_next     = DIR_ZERO;
                        count_next   = '0;
                    end
                    else
                    begin
                        holding_next   = 1'b1;
                        target_next    = cmd.target;
                        dir_next       = cmd.direction[1] ? DIR_NEG : DIR_POS;
                        count_next     = '0;
                        countdown_next = cfg.start_delay;
                        res.valid      = 1'b1;
                        res.target     = cmd.target;
                        res.amount     = cmd.direction[1] ? -5'sd1 : 5'sd1;
                    end
                end
                OP_RELEASE:
                begin
                    holding_next = 1'b0;
                    target_next  = '0;
                    dir_next     = DIR_ZERO;
                    count_next   = '0;
                end
                OP_TICK:
                begin
                    if (holding_reg && (dir_reg != DIR_ZERO))
                    begin
                        countdown_next = cd_dec;
                        if (cd_dec == '0)
                        begin
                            count_next     = count_inc;
                            countdown_next = interval;
                            res.valid      = 1'b1;
                        end
                    end
                end
                OP_UNUSED:
                begin
                    holding_next = holding_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holding_reg   <= 1'b0;
            target_reg    <= '0;
            dir_reg       <= DIR_ZERO;
            count_reg     <= '0;
            countdown_reg <= '0;
        end
        else
        begin
            holding_reg   <= holding_next;
            target_reg    <= target_next;
            dir_reg       <= dir_next;
            count_reg     <= count_next;
            countdown_reg <= countdown_next;
        end
    end

endmodule

[src/accelerating_auto_repeat_unit.sv]
// ----------------------------------------------------------------------------
// Accelerating auto-repeat unit
// Hold-to-accelerate step generator with an input and a result register.
// ----------------------------------------------------------------------------
// The unit takes one request per cycle while its result is not stalled and
// delivers its step, if any, through the input register and then the result
// register. The hold state is updated combinationally between those two
// registers, which sets the rate of one request per clock. Configuration
// writes are always taken and are meant for an idle unit.
module accelerating_auto_repeat_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          opcode,
    input  logic [aar_pkg::TARGET_W-1:0]        target,
    input  logic signed [aar_pkg::DIR_W-1:0]    direction,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [aar_pkg::TARGET_W-1:0]        step_target,
    output logic signed [aar_pkg::AMOUNT_W-1:0] step_amount,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [aar_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [aar_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import aar_pkg::*;

    aar_cfg_t cfg;
    aar_res_t res;

    logic     s1_valid_reg;
    aar_cmd_t s1_cmd_reg;
    logic     out_valid_reg;
    logic [TARGET_W-1:0]        out_target_reg;
    logic signed [AMOUNT_W-1:0] out_amount_reg;

    logic out_open;
    logic s1_fire;
    logic in_fire;

    assign out_open  = !out_valid_reg || out_ready;
    assign s1_fire   = s1_valid_reg && out_open;
    assign in_ready  = !s1_valid_reg || out_open;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    aar_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    aar_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (s1_fire),
        .cmd   (s1_cmd_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (out_open)
                out_valid_reg <= s1_fire && res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_cmd_reg.opcode    <= opcode_t'(opcode);
            s1_cmd_reg.target    <= target;
            s1_cmd_reg.direction <= direction;
        end
        if (s1_fire && res.valid)
        begin
            out_target_reg <= res.target;
            out_amount_reg <= res.amount;
        end
    end

    assign out_valid   = out_valid_reg;
    assign step_target = out_target_reg;
    assign step_amount = out_amount_reg;

endmodule

[src/aar_checker.sv]
// ----------------------------------------------------------------------------
// Accelerating auto-repeat port checker
// Checks on the port behavior of the accelerating auto-repeat unit.
// ----------------------------------------------------------------------------
module aar_port_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [aar_pkg::TARGET_W-1:0]        step_target,
    input logic signed [aar_pkg::AMOUNT_W-1:0] step_amount
);
    import aar_pkg::*;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(step_target) && $stable(step_amount))
        else $error("result payload changed while stalled");

    // Input backpressure only comes from a stalled result.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a stalled result");

    // A step never exceeds fifteen in magnitude.
    a_amount_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> step_amount != 5'sb10000)
        else $error("step amount out of range");

endmodule

bind accelerating_auto_repeat_unit aar_port_checker u_aar_port_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .step_target (step_target),
    .step_amount (step_amount)
);
